### sv/cordic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cordic_pkg
// Shared types, constants and the arctangent table of the CORDIC unit.
// ----------------------------------------------------------------------------
package cordic_pkg;

    localparam int ITERATIONS_DEF  = 15;
    localparam int COORD_WIDTH_DEF = 24;
    localparam int TABLE_LEN       = 15;

    localparam int ANGLE_W = 17;   // atan2 result, degrees*256
    localparam int UNIT_W  = 21;   // sine/cosine, times 1e6
    localparam int THETA_W = 16;   // rotation angle, degrees*256
    localparam int Z_W     = 18;   // angle accumulator

    localparam logic signed [Z_W-1:0]     HALF_TURN     = 18'sd46080;
    localparam logic signed [THETA_W-1:0] QUARTER_THETA = 16'sd23040;
    localparam logic signed [ANGLE_W-1:0] QUARTER_ANGLE = 17'sd23040;
    localparam logic signed [ANGLE_W-1:0] HALF_ANGLE    = 17'sd46080;
    localparam logic signed [UNIT_W-1:0]  UNIT_OUT      = 21'sd1000000;
    localparam int START_GAIN = 607252;
    localparam int UNIT_SCALE = 1000000;

    localparam logic MODE_VECTOR = 1'b0;
    localparam logic MODE_ROTATE = 1'b1;

    typedef enum logic [1:0] {
        QUAD_1,
        QUAD_2,
        QUAD_3,
        QUAD_4
    } quad_t;

    typedef enum logic [2:0] {
        SP_NONE,
        SP_ZERO_ANG,
        SP_POS_Y,
        SP_NEG_Y,
        SP_NEG_X,
        SP_ROT_ZERO,
        SP_ROT_NINETY
    } spec_t;

    // Control that travels with each request down the pipeline
    typedef struct packed {
        logic               mode;
        spec_t              spec;
        quad_t              quad;
        logic [Z_W-1:0]     z;
        logic [THETA_W-1:0] theta;
    } ctrl_t;

    function automatic logic [Z_W-1:0] atan_entry(input int idx);
        logic [Z_W-1:0] val;
        begin
            case (idx)
                0:       val = 18'd11520;
                1:       val = 18'd6801;
                2:       val = 18'd3593;
                3:       val = 18'd1824;
                4:       val = 18'd916;
                5:       val = 18'd458;
                6:       val = 18'd229;
                7:       val = 18'd115;
                8:       val = 18'd57;
                9:       val = 18'd29;
                10:      val = 18'd14;
                11:      val = 18'd7;
                12:      val = 18'd4;
                13:      val = 18'd2;
                14:      val = 18'd1;
                default: val = 18'd0;
            endcase
            return val;
        end
    endfunction

endpackage

### sv/cordic_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cordic_in_if
// Request channel: mode, coordinates and rotation angle.
// ----------------------------------------------------------------------------
interface cordic_in_if #(
    parameter int COORD_WIDTH = cordic_pkg::COORD_WIDTH_DEF
);
    logic                             valid;
    logic                             ready;
    logic                             mode;
    logic signed [COORD_WIDTH-1:0]    x_in;
    logic signed [COORD_WIDTH-1:0]    y_in;
    logic signed [cordic_pkg::THETA_W-1:0] angle_in;

    modport source (output valid, mode, x_in, y_in, angle_in, input ready);
    modport sink   (input valid, mode, x_in, y_in, angle_in, output ready);
endinterface

### sv/cordic_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cordic_out_if
// Result channel: atan2 angle, sine and cosine.
// ----------------------------------------------------------------------------
interface cordic_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [cordic_pkg::ANGLE_W-1:0] angle_out;
    logic signed [cordic_pkg::UNIT_W-1:0]  sine_out;
    logic signed [cordic_pkg::UNIT_W-1:0]  cosine_out;

    modport source (output valid, angle_out, sine_out, cosine_out, input ready);
    modport sink   (input valid, angle_out, sine_out, cosine_out, output ready);
endinterface

### sv/cordic_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cordic_stage
// One registered shift-add micro-rotation for both vectoring and rotation.
// ----------------------------------------------------------------------------
module cordic_stage #(
    parameter int DW    = 27,
    parameter int STAGE = 0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [DW-1:0]    in_x,
    input  logic signed [DW-1:0]    in_y,
    input  cordic_pkg::ctrl_t       in_ctrl,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [DW-1:0]    out_x,
    output logic signed [DW-1:0]    out_y,
    output cordic_pkg::ctrl_t       out_ctrl
);

    logic                             valid_reg;
    logic signed [DW-1:0]             x_reg, x_next;
    logic signed [DW-1:0]             y_reg, y_next;
    cordic_pkg::ctrl_t                ctrl_reg, ctrl_next;
    logic signed [DW-1:0]             x_sh, y_sh;
    logic signed [cordic_pkg::Z_W-1:0] z, th, step;
    logic                             dir;

    always_comb
    begin
        x_sh = in_x >>> STAGE;
        y_sh = in_y >>> STAGE;
        z    = $signed(in_ctrl.z);
        th   = cordic_pkg::Z_W'($signed(in_ctrl.theta));
        step = $signed(cordic_pkg::atan_entry(STAGE));
        // vectoring drives y to zero, rotation drives z to the target
        if (in_ctrl.mode == cordic_pkg::MODE_ROTATE)
            dir = (z > th);
        else
            dir = !in_y[DW-1] && (|in_y);
        if (dir)
        begin
            x_next = in_x + y_sh;
            y_next = in_y - x_sh;
        end
        else
        begin
            x_next = in_x - y_sh;
            y_next = in_y + x_sh;
        end
        ctrl_next = in_ctrl;
        if (dir ^ in_ctrl.mode)
            ctrl_next.z = z + step;
        else
            ctrl_next.z = z - step;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            ctrl_reg <= ctrl_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_ctrl  = ctrl_reg;

endmodule

### sv/cordic_atan2_sin_cos_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cordic_atan2_sin_cos_top
// Pipelined CORDIC: atan2 in vectoring mode, sine/cosine in rotation mode.
// ----------------------------------------------------------------------------
// Pipeline: one setup stage, one stage per micro-rotation, one output stage.
// Throughput: one request per cycle unless the result channel stalls; every
//   stage holds its own valid bit and moves on as soon as the stage after it
//   frees up, so bubbles collapse.
// Reset: rst_n clears all valid bits at once; data registers are not reset.
// ----------------------------------------------------------------------------
module cordic_atan2_sin_cos_top #(
    parameter int ITERATIONS  = cordic_pkg::ITERATIONS_DEF,
    parameter int COORD_WIDTH = cordic_pkg::COORD_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    cordic_in_if.sink    operand,
    cordic_out_if.source result
);

    // Datapath width: folded coordinates grow by sqrt(2) times the CORDIC
    // gain; rotation needs room for the 1e6-scale vector.
    localparam int DW = (COORD_WIDTH + 3 > 22) ? COORD_WIDTH + 3 : 22;
    localparam int ZW = cordic_pkg::Z_W;

    // Stage interconnect: index 0 is the setup stage, index k its k-th
    // micro-rotation.
    logic                 it_valid [ITERATIONS+1];
    logic                 it_ready [ITERATIONS+1];
    logic signed [DW-1:0] it_x     [ITERATIONS+1];
    logic signed [DW-1:0] it_y     [ITERATIONS+1];
    cordic_pkg::ctrl_t    it_ctrl  [ITERATIONS+1];

    // ------------------------------------------------------------------
    // Setup stage: fold the point into quadrant one, clamp the angle and
    // flag the axis and exact-angle special cases.
    // ------------------------------------------------------------------
    logic                 s0_valid_reg;
    logic signed [DW-1:0] s0_x_reg, s0_x_next;
    logic signed [DW-1:0] s0_y_reg, s0_y_next;
    cordic_pkg::ctrl_t    s0_ctrl_reg, s0_ctrl_next;

    logic signed [DW-1:0] xs, ys;
    logic                 x_zero, y_zero, x_neg, y_neg, x_pos, y_pos;
    logic signed [cordic_pkg::THETA_W-1:0] theta;

    always_comb
    begin
        xs     = {{(DW-COORD_WIDTH){operand.x_in[COORD_WIDTH-1]}}, operand.x_in};
        ys     = {{(DW-COORD_WIDTH){operand.y_in[COORD_WIDTH-1]}}, operand.y_in};
        x_zero = (xs == '0);
        y_zero = (ys == '0);
        x_neg  = xs[DW-1];
        y_neg  = ys[DW-1];
        x_pos  = !x_neg && !x_zero;
        y_pos  = !y_neg && !y_zero;

        // clamp to plus or minus ninety degrees
        theta = operand.angle_in;
        if (theta > cordic_pkg::QUARTER_THETA)
            theta = cordic_pkg::QUARTER_THETA;
        else if (theta < -cordic_pkg::QUARTER_THETA)
            theta = -cordic_pkg::QUARTER_THETA;

        s0_ctrl_next.mode  = operand.mode;
        s0_ctrl_next.spec  = cordic_pkg::SP_NONE;
        s0_ctrl_next.quad  = cordic_pkg::QUAD_1;
        s0_ctrl_next.z     = '0;
        s0_ctrl_next.theta = '0;
        s0_x_next          = '0;
        s0_y_next          = '0;

        if (operand.mode == cordic_pkg::MODE_ROTATE)
        begin
            // start from the gain-compensated unit vector
            s0_x_next          = DW'(cordic_pkg::START_GAIN);
            s0_ctrl_next.theta = theta;
            if (theta == '0)
                s0_ctrl_next.spec = cordic_pkg::SP_ROT_ZERO;
            else if (theta == cordic_pkg::QUARTER_THETA)
                s0_ctrl_next.spec = cordic_pkg::SP_ROT_NINETY;
        end
        else if (x_pos && y_pos)
        begin
            s0_x_next = xs;
            s0_y_next = ys;
        end
        else if (x_neg && y_pos)
        begin
            s0_x_next         = -xs;
            s0_y_next         = ys;
            s0_ctrl_next.quad = cordic_pkg::QUAD_2;
        end
        else if (x_neg && y_neg)
        begin
            s0_x_next         = -xs;
            s0_y_next         = -ys;
            s0_ctrl_next.quad = cordic_pkg::QUAD_3;
        end
        else if (x_pos && y_neg)
        begin
            s0_x_next         = xs;
            s0_y_next         = -ys;
            s0_ctrl_next.quad = cordic_pkg::QUAD_4;
        end
        else if (x_zero && y_pos)
            s0_ctrl_next.spec = cordic_pkg::SP_POS_Y;
        else if (x_zero && y_neg)
            s0_ctrl_next.spec = cordic_pkg::SP_NEG_Y;
        else if (y_zero && x_neg)
            s0_ctrl_next.spec = cordic_pkg::SP_NEG_X;
        else
            s0_ctrl_next.spec = cordic_pkg::SP_ZERO_ANG; // origin, positive x axis
    end

    assign operand.ready = !s0_valid_reg || it_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (operand.ready)
            s0_valid_reg <= operand.valid;
    end

    always_ff @(posedge clk)
    begin
        if (operand.ready && operand.valid)
        begin
            s0_x_reg    <= s0_x_next;
            s0_y_reg    <= s0_y_next;
            s0_ctrl_reg <= s0_ctrl_next;
        end
    end

    assign it_valid[0] = s0_valid_reg;
    assign it_x[0]     = s0_x_reg;
    assign it_y[0]     = s0_y_reg;
    assign it_ctrl[0]  = s0_ctrl_reg;

    // ------------------------------------------------------------------
    // Micro-rotation stages, one per table entry.
    // ------------------------------------------------------------------
    for (genvar k = 0; k < ITERATIONS; k++)
    begin : g_iter
        cordic_stage #(
            .DW    (DW),
            .STAGE (k)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (it_valid[k]),
            .in_ready  (it_ready[k]),
            .in_x      (it_x[k]),
            .in_y      (it_y[k]),
            .in_ctrl   (it_ctrl[k]),
            .out_valid (it_valid[k+1]),
            .out_ready (it_ready[k+1]),
            .out_x     (it_x[k+1]),
            .out_y     (it_y[k+1]),
            .out_ctrl  (it_ctrl[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Output stage: quadrant correction, saturation and special results.
    // This register is the result register seen on the port.
    // ------------------------------------------------------------------
    cordic_pkg::ctrl_t                   fin_ctrl;
    logic signed [DW-1:0]                fin_x, fin_y;
    logic signed [ZW-1:0]                fin_z, corr_z;
    logic signed [cordic_pkg::ANGLE_W-1:0] angle_next, angle_reg;
    logic signed [cordic_pkg::UNIT_W-1:0]  sine_next, sine_reg;
    logic signed [cordic_pkg::UNIT_W-1:0]  cosine_next, cosine_reg;
    logic signed [DW-1:0]                unit_hi, unit_lo;
    logic                                out_valid_reg;

    always_comb
    begin
        fin_ctrl = it_ctrl[ITERATIONS];
        fin_x    = it_x[ITERATIONS];
        fin_y    = it_y[ITERATIONS];
        fin_z    = $signed(fin_ctrl.z);
        unit_hi  = DW'(cordic_pkg::UNIT_SCALE);
        unit_lo  = -unit_hi;

        case (fin_ctrl.quad)
            cordic_pkg::QUAD_2: corr_z = cordic_pkg::HALF_TURN - fin_z;
            cordic_pkg::QUAD_3: corr_z = fin_z - cordic_pkg::HALF_TURN;
            cordic_pkg::QUAD_4: corr_z = -fin_z;
            default:            corr_z = fin_z;
        endcase

        angle_next  = '0;
        sine_next   = '0;
        cosine_next = '0;

        if (fin_ctrl.mode == cordic_pkg::MODE_ROTATE)
        begin
            // saturate to plus or minus one
            if (fin_y > unit_hi)
                sine_next = cordic_pkg::UNIT_OUT;
            else if (fin_y < unit_lo)
                sine_next = -cordic_pkg::UNIT_OUT;
            else
                sine_next = fin_y[cordic_pkg::UNIT_W-1:0];
            if (fin_x > unit_hi)
                cosine_next = cordic_pkg::UNIT_OUT;
            else if (fin_x < unit_lo)
                cosine_next = -cordic_pkg::UNIT_OUT;
            else
                cosine_next = fin_x[cordic_pkg::UNIT_W-1:0];
        end
        else
            angle_next = corr_z[cordic_pkg::ANGLE_W-1:0];

        unique case (fin_ctrl.spec)
            cordic_pkg::SP_NONE:       ;
            cordic_pkg::SP_ZERO_ANG:   angle_next = '0;
            cordic_pkg::SP_POS_Y:      angle_next = cordic_pkg::QUARTER_ANGLE;
            cordic_pkg::SP_NEG_Y:      angle_next = -cordic_pkg::QUARTER_ANGLE;
            cordic_pkg::SP_NEG_X:      angle_next = -cordic_pkg::HALF_ANGLE;
            cordic_pkg::SP_ROT_ZERO:
            begin
                sine_next   = '0;
                cosine_next = cordic_pkg::UNIT_OUT;
            end
            cordic_pkg::SP_ROT_NINETY:
            begin
                sine_next   = cordic_pkg::UNIT_OUT;
                cosine_next = '0;
            end
            default:                   ;
        endcase
    end

    assign it_ready[ITERATIONS] = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (it_ready[ITERATIONS])
            out_valid_reg <= it_valid[ITERATIONS];
    end

    always_ff @(posedge clk)
    begin
        if (it_ready[ITERATIONS] && it_valid[ITERATIONS])
        begin
            angle_reg  <= angle_next;
            sine_reg   <= sine_next;
            cosine_reg <= cosine_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.angle_out  = angle_reg;
    assign result.sine_out   = sine_reg;
    assign result.cosine_out = cosine_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_fills_setup : assert property (
        @(posedge clk) disable iff (!rst_n)
        operand.valid && operand.ready |=> s0_valid_reg)
        else $error("accepted request did not reach the setup stage");

    a_last_stage_to_output : assert property (
        @(posedge clk) disable iff (!rst_n)
        it_valid[ITERATIONS] && it_ready[ITERATIONS] |=> result.valid)
        else $error("request lost between last stage and output");

    a_rotate_zero_angle : assert property (
        @(posedge clk) disable iff (!rst_n)
        it_valid[ITERATIONS] && it_ready[ITERATIONS]
            && fin_ctrl.mode == cordic_pkg::MODE_ROTATE
        |=> result.angle_out == '0)
        else $error("rotation result carries a nonzero angle");

    a_vector_zero_trig : assert property (
        @(posedge clk) disable iff (!rst_n)
        it_valid[ITERATIONS] && it_ready[ITERATIONS]
            && fin_ctrl.mode == cordic_pkg::MODE_VECTOR
        |=> result.sine_out == '0 && result.cosine_out == '0)
        else $error("vectoring result carries nonzero sine or cosine");

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pipelined CORDIC atan2 / sine-cosine unit.
// Drives requests in both modes through the request channel. Each accepted
// request goes to an in-bench fixed-point CORDIC predictor. Each result taken
// from the result channel is matched in order against the predicted values.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int RANDOM_REQUESTS = 1250;
    localparam int CALM_TAIL       = 150;     // final requests run with no idling
    localparam int PHASE_LEN       = 150;     // requests per idling profile
    localparam int DRAIN_CYCLES    = 40;      // outlasts the full pipeline
    localparam int CYCLE_LIMIT     = 200000;

    localparam int CW = cordic_pkg::COORD_WIDTH_DEF;
    localparam int TW = cordic_pkg::THETA_W;
    localparam int AW = cordic_pkg::ANGLE_W;
    localparam int UW = cordic_pkg::UNIT_W;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts each request, holds predictions in arrival order
    // and matches results against them.
    // ------------------------------------------------------------------------
    class cordic_checker;
        typedef struct {
            logic signed [AW-1:0] angle;
            logic signed [UW-1:0] sine;
            logic signed [UW-1:0] cosine;
        } trig_result_t;

        localparam int STAGES = cordic_pkg::ITERATIONS_DEF;

        int           arctan_deg256[15] = '{11520, 6801, 3593, 1824, 916, 458, 229,
                                            115, 57, 29, 14, 7, 4, 2, 1};
        trig_result_t awaited_results[$];
        int           errors;
        int           checked;

        function longint atan2_deg256(longint x, longint y);
            longint             sum;
            longint             nx;
            longint             ny;
            cordic_pkg::quad_t  quad;
            sum = 0;
            if (x > 0 && y > 0)
                quad = cordic_pkg::QUAD_1;
            else if (x < 0 && y > 0)
            begin
                x = -x;
                quad = cordic_pkg::QUAD_2;
            end
            else if (x < 0 && y < 0)
            begin
                x = -x;
                y = -y;
                quad = cordic_pkg::QUAD_3;
            end
            else if (x > 0 && y < 0)
            begin
                y = -y;
                quad = cordic_pkg::QUAD_4;
            end
            else if (x == 0 && y > 0)
                return longint'(cordic_pkg::QUARTER_ANGLE);
            else if (x == 0 && y < 0)
                return -longint'(cordic_pkg::QUARTER_ANGLE);
            else if (y == 0 && x < 0)
                return -longint'(cordic_pkg::HALF_ANGLE);
            else
                return 0;

            for (int i = 0; i < STAGES; i++)
            begin
                if (y > 0)
                begin
                    nx = x + (y >>> i);
                    ny = y - (x >>> i);
                    sum += arctan_deg256[i];
                end
                else
                begin
                    nx = x - (y >>> i);
                    ny = y + (x >>> i);
                    sum -= arctan_deg256[i];
                end
                x = nx;
                y = ny;
            end

            case (quad)
                cordic_pkg::QUAD_2: sum = longint'(cordic_pkg::HALF_ANGLE) - sum;
                cordic_pkg::QUAD_3: sum = sum - longint'(cordic_pkg::HALF_ANGLE);
                cordic_pkg::QUAD_4: sum = -sum;
                default:            ;
            endcase
            return sum;
        endfunction

        function longint clip_unit(longint v);
            if (v > cordic_pkg::UNIT_SCALE)
                return cordic_pkg::UNIT_SCALE;
            if (v < -cordic_pkg::UNIT_SCALE)
                return -cordic_pkg::UNIT_SCALE;
            return v;
        endfunction

        function void sin_cos_1e6(input longint theta, output longint s,
                                  output longint c);
            longint x;
            longint y;
            longint sum;
            longint nx;
            longint ny;
            x = cordic_pkg::START_GAIN;
            y = 0;
            sum = 0;
            if (theta > longint'(cordic_pkg::QUARTER_ANGLE))
                theta = longint'(cordic_pkg::QUARTER_ANGLE);
            if (theta < -longint'(cordic_pkg::QUARTER_ANGLE))
                theta = -longint'(cordic_pkg::QUARTER_ANGLE);
            if (theta == 0)
            begin
                s = 0;
                c = cordic_pkg::UNIT_SCALE;
                return;
            end
            if (theta == longint'(cordic_pkg::QUARTER_ANGLE))
            begin
                s = cordic_pkg::UNIT_SCALE;
                c = 0;
                return;
            end
            for (int i = 0; i < STAGES; i++)
            begin
                if (sum > theta)
                begin
                    nx = x + (y >>> i);
                    ny = y - (x >>> i);
                    sum -= arctan_deg256[i];
                end
                else
                begin
                    nx = x - (y >>> i);
                    ny = y + (x >>> i);
                    sum += arctan_deg256[i];
                end
                x = nx;
                y = ny;
            end
            s = clip_unit(y);
            c = clip_unit(x);
        endfunction

        function void note_request(logic mode, logic signed [CW-1:0] x,
                                   logic signed [CW-1:0] y,
                                   logic signed [TW-1:0] theta);
            trig_result_t r;
            longint       s;
            longint       c;
            r.angle  = '0;
            r.sine   = '0;
            r.cosine = '0;
            if (mode == cordic_pkg::MODE_VECTOR)
                r.angle = AW'(atan2_deg256(longint'(x), longint'(y)));
            else
            begin
                sin_cos_1e6(longint'(theta), s, c);
                r.sine   = UW'(s);
                r.cosine = UW'(c);
            end
            awaited_results.push_back(r);
        endfunction

        function void check_result(logic signed [AW-1:0] angle,
                                   logic signed [UW-1:0] sine,
                                   logic signed [UW-1:0] cosine);
            trig_result_t want;
            if (awaited_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("[%0t] unexpected result: angle %0d sine %0d cosine %0d",
                             $realtime, angle, sine, cosine);
                return;
            end
            want = awaited_results.pop_front();
            checked++;
            if (angle !== want.angle || sine !== want.sine || cosine !== want.cosine)
            begin
                errors++;
                if (errors <= 10)
                    $display({"[%0t] mismatch #%0d: angle exp %0d got %0d",
                              " | sine exp %0d got %0d | cosine exp %0d got %0d"},
                             $realtime, checked, want.angle, angle, want.sine, sine,
                             want.cosine, cosine);
            end
        endfunction

        function int pending_count();
            return awaited_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block under test
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    always #1 clk = ~clk;

    cordic_in_if  req_if ();
    cordic_out_if res_if ();

    cordic_atan2_sin_cos_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .operand (req_if),
        .result  (res_if)
    );

    cordic_checker board;

    // Idling odds in percent per request (source) and per cycle (sink)
    int src_idle_pct;
    int snk_idle_pct;

    int n_vector;
    int n_rotate;
    int n_axis;
    int n_clamped;
    int cycles;

    // Hard stop: far beyond the slowest legal run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result sink: stall in bursts of random length when asked to
    initial
    begin
        res_if.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (snk_idle_pct != 0 && $urandom_range(1, 100) <= snk_idle_pct)
            begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // Result monitor: everything only changes at rising edges, so the values
    // seen at the falling edge are the ones the next rising edge will take.
    always @(negedge clk)
    begin
        if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1)
            board.check_result(res_if.angle_out, res_if.sine_out, res_if.cosine_out);
    end

    // ------------------------------------------------------------------------
    // Request driver: optionally idle for a burst, present one request and
    // hold it until the block takes it, then log the prediction.
    // ------------------------------------------------------------------------
    task automatic send_request(input logic mode, input logic signed [CW-1:0] x,
                                input logic signed [CW-1:0] y,
                                input logic signed [TW-1:0] theta);
        logic took;
        if (src_idle_pct != 0 && $urandom_range(1, 100) <= src_idle_pct)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        req_if.valid    <= 1'b1;
        req_if.mode     <= mode;
        req_if.x_in     <= x;
        req_if.y_in     <= y;
        req_if.angle_in <= theta;
        do
        begin
            @(negedge clk);
            took = req_if.ready;
            @(posedge clk);
        end
        while (took !== 1'b1);
        board.note_request(mode, x, y, theta);
        if (mode == cordic_pkg::MODE_VECTOR)
        begin
            n_vector++;
            if (x == 0 || y == 0)
                n_axis++;
        end
        else
        begin
            n_rotate++;
            if (theta > cordic_pkg::QUARTER_THETA || theta < -cordic_pkg::QUARTER_THETA)
                n_clamped++;
        end
    endtask

    task automatic send_vector(input int x, input int y);
        send_request(cordic_pkg::MODE_VECTOR, CW'(x), CW'(y), TW'($urandom));
    endtask

    task automatic send_rotate(input int theta);
        send_request(cordic_pkg::MODE_ROTATE, CW'($urandom), CW'($urandom), TW'(theta));
    endtask

    // One random request; mostly in-range content with a share of edge cases
    task automatic send_random();
        int pick;
        int mag;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            send_request(cordic_pkg::MODE_VECTOR, CW'($urandom), CW'($urandom),
                         TW'($urandom));
        else if (pick < 55)
            send_vector(int'($urandom_range(0, 40000)) - 20000,
                        int'($urandom_range(0, 40000)) - 20000);
        else if (pick < 60)
        begin
            // land on an axis or the origin
            mag = $urandom_range(0, 3) == 0 ? 0 : int'($urandom_range(0, 16777215)) - 8388608;
            if ($urandom_range(0, 1) == 0)
                send_vector(0, mag);
            else
                send_vector(mag, 0);
        end
        else if (pick < 85)
            send_rotate(int'($urandom_range(0, 46080)) - 23040);
        else if (pick < 93)
            send_request(cordic_pkg::MODE_ROTATE, CW'($urandom), CW'($urandom),
                         TW'($urandom));
        else
        begin
            case ($urandom_range(0, 4))
                0:       send_rotate(0);
                1:       send_rotate(23040);
                2:       send_rotate(-23040);
                3:       send_rotate(23041);
                default: send_rotate(-23041);
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        board = new();
        rst_n           <= 1'b0;
        req_if.valid    <= 1'b0;
        req_if.mode     <= cordic_pkg::MODE_VECTOR;
        req_if.x_in     <= '0;
        req_if.y_in     <= '0;
        req_if.angle_in <= '0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: axes, origin, every quadrant, coordinate extremes
        src_idle_pct = 25;
        snk_idle_pct = 25;
        send_vector(0, 0);
        send_vector(0, 5000);
        send_vector(0, -5000);
        send_vector(-7, 0);
        send_vector(9, 0);
        send_vector(10000, 10000);
        send_vector(-10000, 10000);
        send_vector(-10000, -10000);
        send_vector(10000, -10000);
        send_vector(8388607, 8388607);
        send_vector(-8388608, -8388608);
        send_vector(-8388608, 8388607);
        send_vector(8388607, -8388608);
        send_vector(1, -1);

        // Directed: zero, plus/minus ninety, clamping, tiny and mid angles
        send_rotate(0);
        send_rotate(23040);
        send_rotate(-23040);
        send_rotate(32767);
        send_rotate(-32768);
        send_rotate(23041);
        send_rotate(1);
        send_rotate(-1);
        send_rotate(11520);
        send_rotate(-11520);
        send_rotate(23039);

        // Random: switch idling profile every phase, go calm for the tail
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n >= RANDOM_REQUESTS - CALM_TAIL)
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            else if (n % PHASE_LEN == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       src_idle_pct = 0;
                    1:       src_idle_pct = 10;
                    2:       src_idle_pct = 35;
                    default: src_idle_pct = 70;
                endcase
                case ($urandom_range(0, 3))
                    0:       snk_idle_pct = 0;
                    1:       snk_idle_pct = 5;
                    2:       snk_idle_pct = 20;
                    default: snk_idle_pct = 50;
                endcase
            end
            send_random();
        end
        req_if.valid <= 1'b0;

        // Drain: wait for every prediction to be matched, then watch for strays
        while (board.pending_count() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display({"Sent %0d atan2 requests (%0d on an axis or origin)",
                  " and %0d sine/cosine requests (%0d clamped)."},
                 n_vector, n_axis, n_rotate, n_clamped);
        $display("Checked %0d results, %0d mismatches.", board.checked, board.errors);
        if (board.errors == 0 && board.pending_count() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### filelist.f
sv/cordic_pkg.sv
sv/cordic_in_if.sv
sv/cordic_out_if.sv
sv/cordic_stage.sv
sv/cordic_atan2_sin_cos_top.sv
bench/tb_top.sv
